// File: rtl/euler_pose_to_transform_matrix_macros.svh
// assertion macros for the pose to transform block
// used by the top level only, no other dependencies
`ifndef EULER_POSE_TO_TRANSFORM_MATRIX_MACROS_SVH
`define EULER_POSE_TO_TRANSFORM_MATRIX_MACROS_SVH
`ifndef SYNTH
`define EPM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("epm check failed");
`define EPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epm check failed");
`define EPM_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("epm reset check failed");
`else
`define EPM_ASSERT(label, cond)
`define EPM_ASSERT_NEXT(label, ante, cons)
`define EPM_ASSERT_RST(label, cons)
`endif
`endif

// File: rtl/epm_pkg.sv
// shared constants, types and the arctangent table for the pose block
// no dependencies
package epm_pkg;

  localparam int MATRIX_FRAC_BITS_DEF = 14;
  localparam int INT_FRAC = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int IW = 34;

  typedef logic signed [IW-1:0] fix_t;

  localparam fix_t CORDIC_GAIN_INV = 34'sd652032874;
  localparam fix_t PI_Q30 = 34'sd3373259426;
  localparam fix_t HALF_PI_Q30 = 34'sd1686629713;

  function automatic fix_t atan_q30(input int idx);
    fix_t r;
    case (idx)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775852;
      7: r = 34'sd8388438;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = fix_t'(34'sd1 <<< (INT_FRAC - idx));
    endcase
    return r;
  endfunction

endpackage

// File: rtl/epm_cordic.sv
// pipelined half-angle sine and cosine, one rotation step per stage
// depends on epm_pkg
module epm_cordic (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  angle,
  output epm_pkg::fix_t       cos_q,
  output epm_pkg::fix_t       sin_q
);
  import epm_pkg::*;

  fix_t xs [0:CORDIC_STEPS];
  fix_t ys [0:CORDIC_STEPS];
  fix_t zs [0:CORDIC_STEPS];
  logic flip [0:CORDIC_STEPS];
  fix_t z_in;

  assign z_in = fix_t'($signed({angle, 16'b0}));

  // range reduction to +-pi/2
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN_INV;
      ys[0] <= '0;
      if (z_in > HALF_PI_Q30) begin
        zs[0] <= z_in - PI_Q30;
        flip[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Q30) begin
        zs[0] <= z_in + PI_Q30;
        flip[0] <= 1'b1;
      end else begin
        zs[0] <= z_in;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam fix_t ATAN = atan_q30(i);
    fix_t dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!zs[i][IW-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= flip[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
      sin_q <= flip[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    end
  end

endmodule

// File: rtl/euler_pose_to_transform_matrix.sv
// roll-pitch-yaw pose to rows 0..2 of a homogeneous transform
// accepts one item per cycle while the output is not stalled
// items pass through the cordic lanes, then five product/sum stages
// a stall at the output freezes the whole pipeline, nothing is dropped
// synchronous active-high reset clears all valid bits
// depends on epm_pkg, epm_cordic and the macros header
`include "euler_pose_to_transform_matrix_macros.svh"
module euler_pose_to_transform_matrix #(
  parameter int MATRIX_FRAC_BITS = epm_pkg::MATRIX_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rot_00 rot_01 rot_02 trans_x rot_10 rot_11 rot_12 trans_y
  // rot_20 rot_21 rot_22 trans_z
  output logic [239:0] m_tdata
);
  import epm_pkg::*;

  localparam int CLAT = CORDIC_STEPS + 2;
  localparam int LAT = CLAT + 5;
  localparam int SH = INT_FRAC - MATRIX_FRAC_BITS;
  localparam int OW = IW + 3;
  localparam logic signed [OW-1:0] RND = (SH > 0) ? (OW'(1) <<< (SH - 1)) : '0;
  localparam logic signed [OW-1:0] ONE_OUT = OW'(1) <<< MATRIX_FRAC_BITS;
  localparam logic signed [OW-1:0] ONE_INT = OW'(1) <<< INT_FRAC;

  logic en;
  logic [LAT-1:0] vld;
  logic [95:0] trans [0:LAT-2];
  fix_t cr, sr, cp, sp, cy, sy;

  assign en = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trans[0] <= s_tdata[95:0];
      for (int k = 1; k < LAT - 1; k++) trans[k] <= trans[k-1];
    end
  end

  epm_cordic u_roll  (.clk(clk), .en(en), .angle(s_tdata[111:96]),
                      .cos_q(cr), .sin_q(sr));
  epm_cordic u_pitch (.clk(clk), .en(en), .angle(s_tdata[127:112]),
                      .cos_q(cp), .sin_q(sp));
  epm_cordic u_yaw   (.clk(clk), .en(en), .angle(s_tdata[143:128]),
                      .cos_q(cy), .sin_q(sy));

  function automatic fix_t qmul(input fix_t a, input fix_t b);
    logic signed [2*IW-1:0] p;
    p = a * b;
    return p[IW+INT_FRAC-1:INT_FRAC];
  endfunction

  function automatic logic [15:0] to_out(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] r;
    r = (v + RND) >>> SH;
    if (r > ONE_OUT) r = ONE_OUT;
    if (r < -ONE_OUT) r = -ONE_OUT;
    return r[15:0];
  endfunction

  // stage 1: pitch-roll products
  fix_t p_sc, p_cs, p_cc, p_ss, cy1, sy1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_sc <= qmul(sr, cp);
      p_cs <= qmul(cr, sp);
      p_cc <= qmul(cr, cp);
      p_ss <= qmul(sr, sp);
      cy1 <= cy;
      sy1 <= sy;
    end
  end

  // stage 2: times yaw terms
  fix_t t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc, t_ccc, t_sss;
  always_ff @(posedge clk) begin
    if (en) begin
      t_scc <= qmul(p_sc, cy1);
      t_css <= qmul(p_cs, sy1);
      t_csc <= qmul(p_cs, cy1);
      t_scs <= qmul(p_sc, sy1);
      t_ccs <= qmul(p_cc, sy1);
      t_ssc <= qmul(p_ss, cy1);
      t_ccc <= qmul(p_cc, cy1);
      t_sss <= qmul(p_ss, sy1);
    end
  end

  // stage 3: quaternion
  fix_t qx, qy, qz, qw;
  always_ff @(posedge clk) begin
    if (en) begin
      qx <= t_scc - t_css;
      qy <= t_csc + t_scs;
      qz <= t_ccs - t_ssc;
      qw <= t_ccc + t_sss;
    end
  end

  // stage 4: quaternion products
  fix_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= qmul(qx, qx);
      yy <= qmul(qy, qy);
      zz <= qmul(qz, qz);
      xy <= qmul(qx, qy);
      xz <= qmul(qx, qz);
      yz <= qmul(qy, qz);
      wx <= qmul(qw, qx);
      wy <= qmul(qw, qy);
      wz <= qmul(qw, qz);
    end
  end

  // stage 5: matrix entries into the output register
  logic signed [OW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  always_comb begin
    e00 = ONE_INT - ((OW'(yy) + OW'(zz)) <<< 1);
    e01 = (OW'(xy) - OW'(wz)) <<< 1;
    e02 = (OW'(xz) + OW'(wy)) <<< 1;
    e10 = (OW'(xy) + OW'(wz)) <<< 1;
    e11 = ONE_INT - ((OW'(xx) + OW'(zz)) <<< 1);
    e12 = (OW'(yz) - OW'(wx)) <<< 1;
    e20 = (OW'(xz) - OW'(wy)) <<< 1;
    e21 = (OW'(yz) + OW'(wx)) <<< 1;
    e22 = ONE_INT - ((OW'(xx) + OW'(yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {trans[LAT-2][95:64], to_out(e22), to_out(e21), to_out(e20),
                  trans[LAT-2][63:32], to_out(e12), to_out(e11), to_out(e10),
                  trans[LAT-2][31:0], to_out(e02), to_out(e01), to_out(e00)};
    end
  end

  `EPM_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld[0])
  `EPM_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld))
  `EPM_ASSERT_RST(a_reset_empty, !m_tvalid)

endmodule
